// File: sv/ial_pkg.sv
// Shared types and constants for the indexed array list block.
// Holds the command, status, state and control-bus definitions used by the controller, datapath and top level.
// Depends on nothing.
package ial_pkg;

  // Payload field widths of the stream channels.
  localparam int CMD_W     = 2;
  localparam int POS_W     = 11;
  localparam int VAL_W     = 32;
  localparam int STS_W     = 2;
  localparam int LEN_W     = 11;
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  // Command codes carried in the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Status codes carried in the output tuser.
  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_INS_LAST,
    ST_DOWN,
    ST_READ
  } state_t;

  // Source of the status and data loaded into the result register.
  typedef enum logic [1:0] {
    RES_ACC,
    RES_OK,
    RES_READ
  } res_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch;
    logic     wr_input;
    logic     wr_latched;
    logic     ptr_load_cnt;
    logic     ptr_load_pos;
    logic     step_up;
    logic     step_dn;
    logic     shift_stop;
    logic     rd_pos;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     res_load;
    res_sel_t res_sel;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    status_t acc_status;
    logic    at_pos;
    logic    at_last;
    logic    out_stall;
  } dp_stat_t;

endpackage

// File: sv/ial_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Used for the entry store of the indexed array list. Depends on nothing.
module ial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ial_datapath.sv
// Datapath of the indexed array list: entry store, length counter, shift pointer,
// command checks and the result register. Depends on ial_pkg and ial_ram.
module ial_datapath #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ial_pkg::dp_ctrl_t             ctrl,
  output ial_pkg::dp_stat_t             stat,
  input  logic [ial_pkg::CMD_W-1:0]     command,
  input  logic [ial_pkg::POS_W-1:0]     position,
  input  logic [ial_pkg::VAL_W-1:0]     value,
  input  logic                          m_tready,
  output logic                          m_valid,
  output logic [ial_pkg::STS_W-1:0]     status,
  output logic [ial_pkg::VAL_W-1:0]     read_value,
  output logic [ial_pkg::LEN_W-1:0]     length
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > ial_pkg::POS_W) ? CNT_W : ial_pkg::POS_W;

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic [AW-1:0]             ptr;
  logic [AW-1:0]             pos_l;
  logic [ial_pkg::VAL_W-1:0] val_l;
  logic                      wr_pend;
  logic [AW-1:0]             wr_addr;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [ial_pkg::VAL_W-1:0] ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic [ial_pkg::VAL_W-1:0] ram_rdata;

  logic [AW-1:0]             pos_a;
  logic [CMP_W-1:0]          pos_c;
  logic [CMP_W-1:0]          cnt_c;
  logic                      full;
  logic                      empty;
  ial_pkg::status_t          acc_status;
  ial_pkg::status_t          res_status;
  logic [ial_pkg::VAL_W-1:0] res_value;

  assign pos_a = AW'(position);
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);

  // Check an incoming command against the current length.
  always_comb begin
    unique case (ial_pkg::cmd_t'(command))
      ial_pkg::CMD_APPEND: begin
        acc_status = full ? ial_pkg::STS_FULL : ial_pkg::STS_OK;
      end
      ial_pkg::CMD_INSERT: begin
        if (full) begin
          acc_status = ial_pkg::STS_FULL;
        end else if (pos_c > cnt_c) begin
          acc_status = ial_pkg::STS_RANGE;
        end else begin
          acc_status = ial_pkg::STS_OK;
        end
      end
      default: begin
        if (empty) begin
          acc_status = ial_pkg::STS_EMPTY;
        end else if (pos_c >= cnt_c) begin
          acc_status = ial_pkg::STS_RANGE;
        end else begin
          acc_status = ial_pkg::STS_OK;
        end
      end
    endcase
  end

  // Status back to the controller.
  assign stat.acc_status = acc_status;
  assign stat.at_pos     = (ptr == pos_l);
  assign stat.at_last    = ((CNT_W'(ptr) + CNT_W'(1)) == count);
  assign stat.out_stall  = m_valid && !m_tready;

  // Length counter update.
  always_comb begin
    count_next = count;
    if (ctrl.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.cnt_dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Read address: the position for a read, or the neighbor of the shift pointer.
  always_comb begin
    if (ctrl.rd_pos) begin
      ram_raddr = pos_a;
    end else if (ctrl.step_up) begin
      ram_raddr = ptr - AW'(1);
    end else begin
      ram_raddr = ptr + AW'(1);
    end
  end

  // Write port: a pending shift write takes the word read in the previous cycle.
  always_comb begin
    ram_we = wr_pend || ctrl.wr_input || ctrl.wr_latched;
    if (wr_pend) begin
      ram_waddr = wr_addr;
      ram_wdata = ram_rdata;
    end else if (ctrl.wr_input) begin
      ram_waddr = count[AW-1:0];
      ram_wdata = value;
    end else begin
      ram_waddr = pos_l;
      ram_wdata = val_l;
    end
  end

  ial_ram #(
    .WIDTH (ial_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control registers: length and pending shift write.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      count <= count_next;
      if (ctrl.step_up || ctrl.step_dn) begin
        wr_pend <= 1'b1;
      end else if (ctrl.shift_stop) begin
        wr_pend <= 1'b0;
      end
    end
  end

  // Operand latch and shift pointer.
  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      pos_l <= pos_a;
      val_l <= value;
    end
    if (ctrl.ptr_load_cnt) begin
      ptr <= count[AW-1:0];
    end else if (ctrl.ptr_load_pos) begin
      ptr <= pos_a;
    end else if (ctrl.step_up) begin
      ptr <= ptr - AW'(1);
    end else if (ctrl.step_dn) begin
      ptr <= ptr + AW'(1);
    end
    if (ctrl.step_up || ctrl.step_dn) begin
      wr_addr <= ptr;
    end
  end

  // Result selection.
  always_comb begin
    unique case (ctrl.res_sel)
      ial_pkg::RES_ACC: begin
        res_status = acc_status;
        res_value  = '0;
      end
      ial_pkg::RES_OK: begin
        res_status = ial_pkg::STS_OK;
        res_value  = '0;
      end
      ial_pkg::RES_READ: begin
        res_status = ial_pkg::STS_OK;
        res_value  = ram_rdata;
      end
      default: begin
        res_status = ial_pkg::STS_OK;
        res_value  = '0;
      end
    endcase
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (ctrl.res_load) begin
      m_valid <= 1'b1;
    end else if (m_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      status     <= res_status;
      read_value <= res_value;
      length     <= ial_pkg::LEN_W'(count_next);
    end
  end

endmodule

// File: sv/ial_ctrl.sv
// Controller state machine of the indexed array list.
// Sequences append, shifted insert and remove, and reads. Depends on ial_pkg.
module ial_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [ial_pkg::CMD_W-1:0] command,
  input  ial_pkg::dp_stat_t         stat,
  output ial_pkg::dp_ctrl_t         ctrl
);

  ial_pkg::state_t state;
  ial_pkg::state_t state_next;
  logic            accept;
  logic            acc_ok;

  assign s_tready = (state == ial_pkg::ST_IDLE) && !stat.out_stall;
  assign accept   = s_tvalid && s_tready;
  assign acc_ok   = (stat.acc_status == ial_pkg::STS_OK);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ial_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ial_pkg::ST_IDLE: begin
        if (accept && acc_ok) begin
          unique case (ial_pkg::cmd_t'(command))
            ial_pkg::CMD_APPEND: state_next = ial_pkg::ST_IDLE;
            ial_pkg::CMD_INSERT: state_next = ial_pkg::ST_UP;
            ial_pkg::CMD_REMOVE: state_next = ial_pkg::ST_DOWN;
            ial_pkg::CMD_READ:   state_next = ial_pkg::ST_READ;
            default:             state_next = ial_pkg::ST_IDLE;
          endcase
        end
      end
      ial_pkg::ST_UP: begin
        if (stat.at_pos) begin
          state_next = ial_pkg::ST_INS_LAST;
        end
      end
      ial_pkg::ST_INS_LAST: state_next = ial_pkg::ST_IDLE;
      ial_pkg::ST_DOWN: begin
        if (stat.at_last) begin
          state_next = ial_pkg::ST_IDLE;
        end
      end
      ial_pkg::ST_READ: state_next = ial_pkg::ST_IDLE;
      default:          state_next = ial_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl         = '0;
    ctrl.res_sel = ial_pkg::RES_ACC;
    unique case (state)
      ial_pkg::ST_IDLE: begin
        if (accept) begin
          ctrl.latch = 1'b1;
          if (!acc_ok) begin
            ctrl.res_load = 1'b1;
          end else begin
            unique case (ial_pkg::cmd_t'(command))
              ial_pkg::CMD_APPEND: begin
                ctrl.wr_input = 1'b1;
                ctrl.cnt_inc  = 1'b1;
                ctrl.res_load = 1'b1;
              end
              ial_pkg::CMD_INSERT: ctrl.ptr_load_cnt = 1'b1;
              ial_pkg::CMD_REMOVE: ctrl.ptr_load_pos = 1'b1;
              ial_pkg::CMD_READ:   ctrl.rd_pos       = 1'b1;
              default:             ctrl.latch        = 1'b1;
            endcase
          end
        end
      end
      // Move entries up one place, from the end down to the position.
      ial_pkg::ST_UP: begin
        if (stat.at_pos) begin
          ctrl.shift_stop = 1'b1;
        end else begin
          ctrl.step_up = 1'b1;
        end
      end
      ial_pkg::ST_INS_LAST: begin
        ctrl.wr_latched = 1'b1;
        ctrl.cnt_inc    = 1'b1;
        ctrl.res_load   = 1'b1;
        ctrl.res_sel    = ial_pkg::RES_OK;
      end
      // Move entries down one place, from the position up to the end.
      ial_pkg::ST_DOWN: begin
        if (stat.at_last) begin
          ctrl.shift_stop = 1'b1;
          ctrl.cnt_dec    = 1'b1;
          ctrl.res_load   = 1'b1;
          ctrl.res_sel    = ial_pkg::RES_OK;
        end else begin
          ctrl.step_dn = 1'b1;
        end
      end
      ial_pkg::ST_READ: begin
        ctrl.res_load = 1'b1;
        ctrl.res_sel  = ial_pkg::RES_READ;
      end
      default: ctrl.res_sel = ial_pkg::RES_ACC;
    endcase
  end

endmodule

// File: sv/indexed_array_list.sv
// Top level of the indexed array list: bounded ordered list of signed 32-bit words.
// Joins the controller and the datapath. Depends on ial_pkg, ial_ctrl, ial_datapath.
//
// Usage: each input transaction is one command (append, insert at position, remove
// at position, read at position) and gives exactly one output transaction with a
// status, the value read (zero unless a read succeeds) and the list length after it.
// Steps from acceptance to a valid result:
//   append and every rejected command: the result is loaded on acceptance
//   read: the entry is read from the store, then loaded into the result register
//   insert: shift up to the position, then write the value; remove: shift down to the end
// The entry store has one write and one registered read port, so a shift moves one
// entry per cycle.
// One command is in flight at a time; the next is taken once its result is loaded.
// The result register holds while the receiver stalls, and no new command is taken
// while it is full and not being read.
// Reset clears the length to zero; stored words are undefined but never read
// before they are written.
module indexed_array_list #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: position [10:0], value [42:11], zero fill [47:43].
  input  logic [ial_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: command [1:0].
  input  logic [ial_pkg::CMD_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: read_value [31:0], length [42:32], zero fill [47:43].
  output logic [ial_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: status [1:0].
  output logic [ial_pkg::STS_W-1:0]     m_tuser
);

  ial_pkg::dp_ctrl_t         ctrl;
  ial_pkg::dp_stat_t         stat;
  logic [ial_pkg::VAL_W-1:0] read_value;
  logic [ial_pkg::LEN_W-1:0] length;

  ial_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .command  (s_tuser),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ial_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .stat       (stat),
    .command    (s_tuser),
    .position   (s_tdata[ial_pkg::POS_W-1:0]),
    .value      (s_tdata[ial_pkg::POS_W+ial_pkg::VAL_W-1:ial_pkg::POS_W]),
    .m_tready   (m_tready),
    .m_valid    (m_tvalid),
    .status     (m_tuser),
    .read_value (read_value),
    .length     (length)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {{(ial_pkg::M_TDATA_W - ial_pkg::VAL_W - ial_pkg::LEN_W){1'b0}},
                    length, read_value};

endmodule
